[sv/bva_pkg.sv]
`default_nettype none

package bva_pkg;

   localparam int MAX_SAMPLES_DEF = 255;

   localparam int RAW_W   = 16;
   localparam int MUL_W   = 14;
   localparam int PROD_W  = RAW_W + MUL_W;
   localparam int MV_SHIFT = 13;
   localparam int MV_W    = 17;
   localparam int NOM_W   = 15;
   localparam int WIN_W   = 17;
   localparam int SIZE_W  = 3;
   localparam int CAL_DIV_W = WIN_W + MV_SHIFT;

   localparam logic [MUL_W-1:0]  MV_MUL       = 14'd8442;
   localparam logic [MV_W-1:0]   FAIL_LOW_MV  = 17'd7700;
   localparam logic [MV_W-1:0]   FAIL_HIGH_MV = 17'd65000;
   localparam logic [MV_W-1:0]   CLASS_24_MV  = 17'd16000;
   localparam logic [MV_W-1:0]   CLASS_36_MV  = 17'd30000;
   localparam logic [MV_W-1:0]   CLASS_48_MV  = 17'd45000;
   localparam logic [RAW_W-1:0]  RAW_ALL_ONES = 16'hFFFF;
   localparam logic [WIN_W-1:0]  WIN_MAX      = 17'h1FFFF;
   localparam logic [NOM_W-1:0]  NOMINAL_RST  = 15'd12000;

   // (x << 13) / 8442 as x * MV_RECIP >> RECIP_SHIFT, exact for a 30-bit dividend
   localparam int RECIP_W     = 32;
   localparam int RECIP_SHIFT = CAL_DIV_W + MUL_W - MV_SHIFT;
   localparam logic [RECIP_W-1:0] MV_RECIP =
      RECIP_W'(((64'd1 << (CAL_DIV_W + MUL_W)) / 64'(MV_MUL)) + 64'd1);

   localparam logic [SIZE_W-1:0] SIZE_12V = 3'd1;
   localparam logic [SIZE_W-1:0] SIZE_24V = 3'd2;
   localparam logic [SIZE_W-1:0] SIZE_36V = 3'd3;
   localparam logic [SIZE_W-1:0] SIZE_48V = 3'd4;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_AVG    = 2'd1;
   localparam logic [1:0] KIND_CAL    = 2'd2;

   typedef struct packed {
      logic latch_item;
      logic do_sample;
      logic cal_mv;
      logic cal_class;
      logic div_start;
      logic cal_nom;
      logic cal_recip;
      logic cal_window;
      logic avg_last;
      logic avg_mul;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic div_done;
   } status_type;

endpackage

`default_nettype wire

[sv/bva_div.sv]
`default_nettype none

module bva_div #(
   parameter int DW = 30,
   parameter int VW = 14
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic      [DW-1:0] quotient,
   output logic               done
);

   localparam int CW = $clog2(DW);

   logic [VW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VW:0]   rem_shift;
   logic [VW+1:0] diff;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DW-1]};
      diff      = {1'b0, rem_shift} - {2'b00, dsr_ff};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dsr_in    = dsr_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // restoring step, one quotient bit per cycle
         rem_in = diff[VW+1] ? rem_shift[VW-1:0] : diff[VW-1:0];
         quo_in = {quo_ff[DW-2:0], ~diff[VW+1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

[sv/bva_datapath.sv]
`default_nettype none

module bva_datapath #(
   parameter int MAX_SAMPLES = bva_pkg::MAX_SAMPLES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [15:0]            req_raw_reading,
   input  wire logic                   req_acked,
   input  wire logic                   csr_wr_en,
   input  wire logic [14:0]            csr_wr_data,
   input  wire bva_pkg::cmd_type       cmd,
   output bva_pkg::status_type         status,
   output logic      [16:0]            rsp_average_mv,
   output logic      [2:0]             rsp_pack_class,
   output logic                        rsp_range_fault,
   output logic                        rsp_sample_taken
);

   import bva_pkg::*;

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = RAW_W + CNT_W;

   logic [RAW_W-1:0]  raw_ff, raw_in;
   logic              acked_ff, acked_in;
   logic [NOM_W-1:0]  nominal_ff, nominal_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [RAW_W-1:0]  last_ff, last_in;
   logic [WIN_W-1:0]  win_low_ff, win_low_in;
   logic [WIN_W-1:0]  win_high_ff, win_high_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic              fail_ff, fail_in;
   logic [MV_W-1:0]   mv_ff, mv_in;
   logic [MV_W-1:0]   avg_mv_ff, avg_mv_in;
   logic              taken_ff, taken_in;
   logic [WIN_W-1:0]  nom_ff, nom_in;
   logic [WIN_W-1:0]  ncnt_ff, ncnt_in;
   logic [MV_W-1:0]   rsp_avg_ff;
   logic [SIZE_W-1:0] rsp_size_ff;
   logic              rsp_fail_ff;
   logic              rsp_taken_ff;

   logic              raw_ok;
   logic              sample_ok;
   logic [PROD_W-1:0] raw_prod;
   logic [PROD_W-1:0] last_prod;
   logic [SIZE_W-1:0] size_calc;
   logic [SIZE_W+NOM_W-1:0] nom_prod;
   logic [WIN_W+RECIP_W-1:0] recip_prod;
   logic [SUM_W-1:0]  quotient;
   logic              div_done;
   logic [WIN_W:0]    win_sum;
   logic [RAW_W-1:0]  avg_counts;

   bva_div #(.DW(SUM_W), .VW(CNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   always_comb begin
      raw_ok    = acked_ff && (raw_ff != '0) && (raw_ff != RAW_ALL_ONES);
      sample_ok = raw_ok && ({1'b0, raw_ff} < win_high_ff) && ({1'b0, raw_ff} > win_low_ff)
                  && (count_ff < CNT_W'(MAX_SAMPLES));
      raw_prod  = {{MUL_W{1'b0}}, raw_ff} * {{RAW_W{1'b0}}, MV_MUL};
      last_prod = {{MUL_W{1'b0}}, last_ff} * {{RAW_W{1'b0}}, MV_MUL};

      if (mv_ff < CLASS_24_MV) begin
         size_calc = SIZE_12V;
      end else if (mv_ff < CLASS_36_MV) begin
         size_calc = SIZE_24V;
      end else if (mv_ff < CLASS_48_MV) begin
         size_calc = SIZE_36V;
      end else begin
         size_calc = SIZE_48V;
      end

      nom_prod   = {{NOM_W{1'b0}}, size_ff} * {{SIZE_W{1'b0}}, nominal_ff};
      recip_prod = {{RECIP_W{1'b0}}, nom_ff} * {{WIN_W{1'b0}}, MV_RECIP};

      win_sum    = {1'b0, ncnt_ff} + {2'b00, ncnt_ff[WIN_W-1:1]};
      avg_counts = (count_ff != '0) ? quotient[RAW_W-1:0] : last_ff;

      raw_in      = raw_ff;
      acked_in    = acked_ff;
      nominal_in  = csr_wr_en ? csr_wr_data : nominal_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      last_in     = last_ff;
      win_low_in  = win_low_ff;
      win_high_in = win_high_ff;
      size_in     = size_ff;
      fail_in     = fail_ff;
      mv_in       = mv_ff;
      avg_mv_in   = avg_mv_ff;
      taken_in    = taken_ff;
      nom_in      = nom_ff;
      ncnt_in     = ncnt_ff;

      if (cmd.latch_item) begin
         raw_in    = req_raw_reading;
         acked_in  = req_acked;
         avg_mv_in = '0;
         taken_in  = 1'b0;
      end
      if (cmd.do_sample && sample_ok) begin
         sum_in   = sum_ff + SUM_W'(raw_ff);
         count_in = count_ff + 1'b1;
         taken_in = 1'b1;
      end
      if (cmd.cal_mv) begin
         mv_in = raw_ok ? raw_prod[PROD_W-1:MV_SHIFT] : '0;
      end
      if (cmd.cal_class) begin
         sum_in   = '0;
         count_in = '0;
         last_in  = '0;
         size_in  = size_calc;
         if ((mv_ff < FAIL_LOW_MV) || (mv_ff > FAIL_HIGH_MV)) begin
            fail_in = 1'b1;
         end
      end
      if (cmd.cal_nom) begin
         nom_in = nom_prod[WIN_W-1:0];
      end
      if (cmd.cal_recip) begin
         ncnt_in = recip_prod[RECIP_SHIFT +: WIN_W];
      end
      if (cmd.cal_window) begin
         win_low_in  = {1'b0, ncnt_ff[WIN_W-1:1]};
         win_high_in = win_sum[WIN_W] ? WIN_MAX : win_sum[WIN_W-1:0];
      end
      if (cmd.avg_last) begin
         last_in  = avg_counts;
         sum_in   = '0;
         count_in = '0;
      end
      if (cmd.avg_mul) begin
         avg_mv_in = last_prod[PROD_W-1:MV_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nominal_ff  <= NOMINAL_RST;
         sum_ff      <= '0;
         count_ff    <= '0;
         last_ff     <= '0;
         win_low_ff  <= '0;
         win_high_ff <= '0;
         size_ff     <= SIZE_12V;
         fail_ff     <= 1'b0;
      end else begin
         nominal_ff  <= nominal_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         last_ff     <= last_in;
         win_low_ff  <= win_low_in;
         win_high_ff <= win_high_in;
         size_ff     <= size_in;
         fail_ff     <= fail_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff    <= raw_in;
      acked_ff  <= acked_in;
      mv_ff     <= mv_in;
      avg_mv_ff <= avg_mv_in;
      taken_ff  <= taken_in;
      nom_ff    <= nom_in;
      ncnt_ff   <= ncnt_in;
      if (cmd.load_rsp) begin
         rsp_avg_ff   <= avg_mv_ff;
         rsp_size_ff  <= size_ff;
         rsp_fail_ff  <= fail_ff;
         rsp_taken_ff <= taken_ff;
      end
   end

   assign status.count_zero = (count_ff == '0);
   assign status.div_done   = div_done;

   assign rsp_average_mv   = rsp_avg_ff;
   assign rsp_pack_class   = rsp_size_ff;
   assign rsp_range_fault  = rsp_fail_ff;
   assign rsp_sample_taken = rsp_taken_ff;

endmodule

`default_nettype wire

[sv/bva_ctrl.sv]
`default_nettype none

module bva_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_kind,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output bva_pkg::cmd_type         cmd,
   input  wire bva_pkg::status_type status
);

   import bva_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SAMPLE    = 4'd1;
   localparam logic [3:0] S_CAL_MUL   = 4'd2;
   localparam logic [3:0] S_CAL_CLS   = 4'd3;
   localparam logic [3:0] S_CAL_NOM   = 4'd4;
   localparam logic [3:0] S_CAL_RECIP = 4'd5;
   localparam logic [3:0] S_CAL_WIN   = 4'd6;
   localparam logic [3:0] S_AVG_DIV   = 4'd7;
   localparam logic [3:0] S_AVG_LAST  = 4'd8;
   localparam logic [3:0] S_AVG_MUL   = 4'd9;
   localparam logic [3:0] S_FINISH    = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_item = 1'b1;
               case (req_kind)
                  KIND_SAMPLE: state_in = S_SAMPLE;
                  KIND_AVG: begin
                     if (status.count_zero) begin
                        state_in = S_AVG_LAST;
                     end else begin
                        cmd.div_start = 1'b1;
                        state_in      = S_AVG_DIV;
                     end
                  end
                  KIND_CAL: state_in = S_CAL_MUL;
                  default:  state_in = S_FINISH;
               endcase
            end
         end
         S_SAMPLE: begin
            cmd.do_sample = 1'b1;
            state_in      = S_FINISH;
         end
         S_CAL_MUL: begin
            cmd.cal_mv = 1'b1;
            state_in   = S_CAL_CLS;
         end
         S_CAL_CLS: begin
            cmd.cal_class = 1'b1;
            state_in      = S_CAL_NOM;
         end
         S_CAL_NOM: begin
            cmd.cal_nom = 1'b1;
            state_in    = S_CAL_RECIP;
         end
         S_CAL_RECIP: begin
            cmd.cal_recip = 1'b1;
            state_in      = S_CAL_WIN;
         end
         S_CAL_WIN: begin
            cmd.cal_window = 1'b1;
            state_in       = S_FINISH;
         end
         S_AVG_DIV: begin
            if (status.div_done) begin
               state_in = S_AVG_LAST;
            end
         end
         S_AVG_LAST: begin
            cmd.avg_last = 1'b1;
            state_in     = S_AVG_MUL;
         end
         S_AVG_MUL: begin
            cmd.avg_mul = 1'b1;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[sv/battery_voltage_averager_core.sv]
// Transfer in to result: unused kind direct to finish; sample via the sample state;
// average with no samples via last and multiply; calibrate via multiply, class,
// nominal, reciprocal and window; average via the radix-2 divider (DW = 16 +
// clog2(MAX_SAMPLES+1) bits, 24 by default), last and multiply. One item at a time;
// the next is taken once the result is registered, which may still wait on output.
// Sync active-high reset: nominal 12000 mV, class 1; sums, window and fail cleared.
`default_nettype none

module battery_voltage_averager_core #(
   parameter int MAX_SAMPLES = bva_pkg::MAX_SAMPLES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [15:0] req_raw_reading,
   input  wire logic        req_acked,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [16:0] rsp_average_mv,
   output logic      [2:0]  rsp_pack_class,
   output logic             rsp_range_fault,
   output logic             rsp_sample_taken,
   input  wire logic        csr_wr_en,
   input  wire logic [14:0] csr_wr_data
);

   import bva_pkg::*;

   cmd_type    cmd;
   status_type status;

   bva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   bva_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_raw_reading  (req_raw_reading),
      .req_acked        (req_acked),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_average_mv   (rsp_average_mv),
      .rsp_pack_class   (rsp_pack_class),
      .rsp_range_fault  (rsp_range_fault),
      .rsp_sample_taken (rsp_sample_taken)
   );

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transfer taken while an item is in flight");

   a_taken_no_avg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_sample_taken && (rsp_average_mv != '0)))
      else $error("result flags a taken sample and an average at once");

   a_size_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_pack_class == SIZE_12V) || (rsp_pack_class == SIZE_24V) ||
                     (rsp_pack_class == SIZE_36V) || (rsp_pack_class == SIZE_48V)))
      else $error("battery size class out of range");

endmodule

`default_nettype wire

[dv/testbench.sv]
module testbench;
   import bva_pkg::*;

   localparam int SAMPLE_CAP = MAX_SAMPLES_DEF;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int LONG_HOLD_AT = 700;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 50;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] raw;
      logic        acked;
   } reading_type;

   typedef struct packed {
      logic [16:0] average_mv;
      logic [2:0]  pack_class;
      logic        range_fault;
      logic        sample_taken;
   } report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [1:0]  req_kind = '0;
   logic [15:0] req_raw_reading = '0;
   logic        req_acked = 1'b0;
   logic        rsp_ready = 1'b0;
   logic        csr_wr_en = 1'b0;
   logic [14:0] csr_wr_data = '0;
   wire         req_ready;
   wire         rsp_valid;
   wire  [16:0] rsp_average_mv;
   wire  [2:0]  rsp_pack_class;
   wire         rsp_range_fault;
   wire         rsp_sample_taken;

   reading_type pending_readings[$];
   report_type  expected_reports[$];
   int       queued_cnt = 0;
   int       issued_cnt = 0;
   int       accepted_cnt = 0;
   int       error_cnt = 0;
   int       gap_left = 0;
   int       stall_left = 0;
   logic     long_hold_done = 1'b0;
   logic     took_req = 1'b0;
   logic     quiet = 1'b0;
   logic [14:0] plan_nominal = NOMINAL_RST;

   // predicted block state
   logic [14:0] nominal_mv;
   logic [31:0] sum_counts;
   int          n_samples;
   logic [15:0] last_avg;
   logic [16:0] win_lo;
   logic [16:0] win_hi;
   logic [2:0]  size_class;
   logic        fail_flag;

   battery_voltage_averager_core #(
      .MAX_SAMPLES(SAMPLE_CAP)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_raw_reading  (req_raw_reading),
      .req_acked        (req_acked),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_average_mv   (rsp_average_mv),
      .rsp_pack_class   (rsp_pack_class),
      .rsp_range_fault  (rsp_range_fault),
      .rsp_sample_taken (rsp_sample_taken),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [16:0] to_millivolts(logic [15:0] counts);
      return 17'((32'(counts) * 32'(MV_MUL)) >> MV_SHIFT);
   endfunction

   function void apply_reading(reading_type r);
      report_type  rep;
      logic        ok;
      logic [16:0] mv;
      logic [31:0] nom_counts;
      logic [31:0] avg;
      ok = r.acked && r.raw != 16'd0 && r.raw != RAW_ALL_ONES;
      rep = '0;
      case (r.kind)
         KIND_SAMPLE: begin
            if (ok && {1'b0, r.raw} < win_hi && {1'b0, r.raw} > win_lo &&
                n_samples < SAMPLE_CAP) begin
               sum_counts = sum_counts + r.raw;
               n_samples++;
               rep.sample_taken = 1'b1;
            end
         end
         KIND_AVG: begin
            avg = (n_samples > 0) ? sum_counts / 32'(n_samples) : 32'(last_avg);
            last_avg = avg[15:0];
            sum_counts = '0;
            n_samples = 0;
            rep.average_mv = to_millivolts(last_avg);
         end
         KIND_CAL: begin
            sum_counts = '0;
            n_samples = 0;
            last_avg = '0;
            mv = ok ? to_millivolts(r.raw) : '0;
            if (mv < FAIL_LOW_MV || mv > FAIL_HIGH_MV)
               fail_flag = 1'b1;
            if (mv < CLASS_24_MV)
               size_class = SIZE_12V;
            else if (mv < CLASS_36_MV)
               size_class = SIZE_24V;
            else if (mv < CLASS_48_MV)
               size_class = SIZE_36V;
            else
               size_class = SIZE_48V;
            nom_counts = ((32'(size_class) * 32'(nominal_mv)) << MV_SHIFT) / 32'(MV_MUL);
            win_lo = 17'(nom_counts >> 1);
            if (nom_counts + (nom_counts >> 1) > 32'(WIN_MAX))
               win_hi = WIN_MAX;
            else
               win_hi = 17'(nom_counts + (nom_counts >> 1));
         end
         default: ;
      endcase
      rep.pack_class = size_class;
      rep.range_fault = fail_flag;
      expected_reports.push_back(rep);
   endfunction

   task automatic check_field(string name, logic [16:0] want, logic [16:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_cnt++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      report_type want;
      took_req <= !reset && req_valid && req_ready;
      if (reset) begin
         nominal_mv = NOMINAL_RST;
         sum_counts = '0;
         n_samples = 0;
         last_avg = '0;
         win_lo = '0;
         win_hi = '0;
         size_class = SIZE_12V;
         fail_flag = 1'b0;
      end else begin
         if (csr_wr_en)
            nominal_mv = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $error("result transfer with nothing outstanding");
               error_cnt++;
            end else begin
               want = expected_reports.pop_front();
               check_field("average_mv", want.average_mv, rsp_average_mv);
               check_field("pack_class", 17'(want.pack_class), 17'(rsp_pack_class));
               check_field("range_fault", 17'(want.range_fault), 17'(rsp_range_fault));
               check_field("sample_taken", 17'(want.sample_taken), 17'(rsp_sample_taken));
            end
         end
         if (req_valid && req_ready) begin
            accepted_cnt++;
            apply_reading('{req_kind, req_raw_reading, req_acked});
         end
      end
   end

   always @(negedge clock) begin : feed
      reading_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || took_req) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_readings.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(0, 10);
            req_valid <= 1'b0;
         end else begin
            nxt = pending_readings.pop_front();
            issued_cnt++;
            req_valid <= 1'b1;
            req_kind <= nxt.kind;
            req_raw_reading <= nxt.raw;
            req_acked <= nxt.acked;
         end
      end
   end

   always @(negedge clock) begin : sink
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!long_hold_done && accepted_cnt >= LONG_HOLD_AT) begin
         // long back-pressure so the block fills and stalls its input
         long_hold_done = 1'b1;
         stall_left = LONG_HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic queue_reading(logic [1:0] kind, logic [15:0] raw, logic acked);
      pending_readings.push_back('{kind, raw, acked});
      queued_cnt++;
   endtask

   task automatic drain();
      do
         @(negedge clock);
      while (pending_readings.size() != 0 || issued_cnt != accepted_cnt ||
             expected_reports.size() != 0);
   endtask

   task automatic set_nominal(logic [14:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      plan_nominal = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_sample(int centre, logic mid_avg);
      int r;
      case ($urandom_range(0, 19))
         0: queue_reading(KIND_SAMPLE, 16'($urandom), 1'($urandom));
         1: queue_reading(KIND_UNUSED, 16'($urandom), 1'($urandom));
         2: begin
            if (mid_avg)
               queue_reading(KIND_AVG, 16'($urandom), 1'($urandom));
            else
               queue_reading(KIND_SAMPLE, 16'($urandom), 1'b0);
         end
         3: begin
            // window edges
            if ($urandom_range(0, 1) == 0)
               r = centre / 2 + $urandom_range(0, 1);
            else
               r = centre + centre / 2 - $urandom_range(0, 1);
            if (r > 65535)
               r = 65535;
            queue_reading(KIND_SAMPLE, 16'(r), 1'b1);
         end
         default: begin
            r = centre / 2 - centre / 8 + $urandom_range(0, centre + centre / 4);
            if (r > 65535)
               r = 65535;
            if (r < 0)
               r = 0;
            queue_reading(KIND_SAMPLE, 16'(r), 1'b1);
         end
      endcase
   endtask

   task automatic queue_session(logic allow_fail);
      int          cls;
      int          n;
      int          centre;
      logic [15:0] raw;
      logic        long_run;
      cls = $urandom_range(1, 4);
      case (cls)
         1: raw = 16'($urandom_range(7480, 15500));
         2: raw = 16'($urandom_range(15540, 29100));
         3: raw = 16'($urandom_range(29120, 43650));
         default: raw = 16'($urandom_range(43680, 63000));
      endcase
      if (allow_fail && $urandom_range(0, 5) == 0)
         queue_reading(KIND_CAL, 16'($urandom), 1'($urandom));
      else
         queue_reading(KIND_CAL, raw, 1'b1);
      centre = cls * int'(plan_nominal) * 8192 / 8442;
      long_run = ($urandom_range(0, 11) == 0);
      n = long_run ? $urandom_range(250, 300) : $urandom_range(0, 40);
      repeat (n) queue_sample(centre, !long_run);
      if ($urandom_range(0, 7) != 0)
         queue_reading(KIND_AVG, 16'($urandom), 1'($urandom));
      if ($urandom_range(0, 7) == 0)
         queue_reading(KIND_AVG, 16'($urandom), 1'($urandom));
   endtask

   task automatic random_phase(logic [14:0] nominal, int n_items, logic allow_fail);
      int stop_at;
      drain();
      set_nominal(nominal);
      stop_at = queued_cnt + n_items;
      while (queued_cnt < stop_at)
         queue_session(allow_fail);
   endtask

   initial begin : stimulus
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      queue_reading(KIND_SAMPLE, 16'd12000, 1'b1);   // window still empty
      queue_reading(KIND_AVG, 16'd0, 1'b1);          // no samples, no history
      queue_reading(KIND_UNUSED, 16'hFFFF, 1'b1);
      queue_reading(KIND_CAL, 16'd12000, 1'b1);
      queue_reading(KIND_SAMPLE, 16'd5822, 1'b1);    // on the lower edge
      queue_reading(KIND_SAMPLE, 16'd5823, 1'b1);
      queue_reading(KIND_SAMPLE, 16'd17465, 1'b1);
      queue_reading(KIND_SAMPLE, 16'd17466, 1'b1);   // on the upper edge
      queue_reading(KIND_SAMPLE, 16'd9000, 1'b0);
      queue_reading(KIND_AVG, 16'hFFFF, 1'b0);
      queue_reading(KIND_AVG, 16'd0, 1'b1);          // reuses last average
      queue_reading(KIND_CAL, 16'd7473, 1'b1);
      queue_reading(KIND_CAL, 16'd15526, 1'b1);
      queue_reading(KIND_CAL, 16'd15527, 1'b1);
      queue_reading(KIND_CAL, 16'd40000, 1'b1);
      queue_reading(KIND_CAL, 16'd63075, 1'b1);
      drain();
      set_nominal(15'h7FFF);
      queue_reading(KIND_CAL, 16'd50000, 1'b1);      // upper window saturates
      queue_reading(KIND_SAMPLE, 16'd63593, 1'b1);
      queue_reading(KIND_SAMPLE, 16'd65534, 1'b1);
      queue_reading(KIND_SAMPLE, 16'hFFFF, 1'b1);
      queue_reading(KIND_AVG, 16'd0, 1'b1);

      random_phase(NOMINAL_RST, 400, 1'b0);

      // sticky fail flag from here on
      drain();
      queue_reading(KIND_CAL, 16'd63076, 1'b1);
      queue_reading(KIND_CAL, 16'd7472, 1'b1);
      queue_reading(KIND_CAL, 16'd0, 1'b1);
      queue_reading(KIND_CAL, 16'hFFFF, 1'b1);
      queue_reading(KIND_CAL, 16'd20000, 1'b0);

      random_phase(15'd1000, 320, 1'b1);
      random_phase(15'd20000, 320, 1'b1);
      random_phase(15'd0, 200, 1'b1);
      random_phase(15'($urandom_range(1000, 20000)), 320, 1'b1);
      drain();
      quiet <= 1'b1;
      random_phase(15'h7FFF, 320, 1'b1);

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_cnt == 0 && expected_reports.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin : watchdog
      #4_800_000;
      $display("simulation failed");
      $finish;
   end

endmodule

[filelist.f]
sv/bva_pkg.sv
sv/bva_div.sv
sv/bva_datapath.sv
sv/bva_ctrl.sv
sv/battery_voltage_averager_core.sv
dv/testbench.sv
